// ===== rtl/sle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  // list capacity in words
  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int POS_W  = 9;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // width wide enough to compare a position against the count
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_LOCATE = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] rd;
    logic [POS_W-1:0]  fp;
    logic [POS_W-1:0]  len;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sequential_list_engine.sv =====
// sequential_list_engine: an ordered list of signed 32-bit words held in one
// on-chip RAM, addressed by 1-based positions.
// Input channel (in_valid/in_ready) carries one request word: op, position,
// item_value. Ops: insert, delete, get, locate first match.
// Output channel (out_valid/out_ready) returns one result word per request:
// ok, read_value, found_position, list_length (length after the request).
// One request is in flight at a time; in_ready is high only when the engine
// is idle. The result sits in an output register, so a new request is taken
// while the previous result still waits for the receiver.
// Insert and delete walk the entries from P (the 1-based position) to the tail, get
// reads one entry, and locate reads from the head until the first match or the end
// of the list; a rejected request goes straight to its response.
// The engine is ready for the next request as out_valid rises, if the output register
// is free; the slowest requests are a delete at the head of a full list and a missed
// locate in it.
// The RAM moves one entry per clock (one read, one write), which sets the walk.
// If the receiver stalls, the finished result waits in the engine until the
// output register frees up, and no further request is taken meanwhile.
// Reset (rst, synchronous) empties the list and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_engine
  import sle_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               op,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] item_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          ok,
  output logic signed [DATA_W-1:0]      read_value,
  output logic [POS_W-1:0]              found_position,
  output logic [POS_W-1:0]              list_length
);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // sequencer: decode, shift walks, search, length tracking
  sle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .position   (position),
    .item_value (item_value),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // entry storage, contents undefined until written
  sle_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (DATA_W),
    .AW_P    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      ok             <= res.ok;
      read_value     <= res.rd;
      found_position <= res.fp;
      list_length    <= res.len;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module sle_ram #(
  parameter int DEPTH_P = 256,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW_P-1:0]    waddr,
  input  wire logic [WIDTH_P-1:0] wdata,
  input  wire logic               re,
  input  wire logic [AW_P-1:0]    raddr,
  output logic      [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sle_ctrl
  import sle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        op,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] item_value,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [DATA_W-1:0]      ram_wdata,
  output logic                   ram_re,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire logic [DATA_W-1:0] ram_rdata,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LOC  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  left;
  logic              pend;
  logic [ADDR_W-1:0] paddr;
  logic [ADDR_W-1:0] tgt;
  logic [DATA_W-1:0] val;
  logic              shift;
  logic              res_ok;
  logic [DATA_W-1:0] res_rd;
  logic [CNT_W-1:0]  res_fp;

  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              pos_nz;
  logic              rd_ok;
  logic              ins_ok;
  logic [ADDR_W-1:0] tgt_in;
  logic [CNT_W-1:0]  ins_moves;
  logic [CNT_W-1:0]  del_len;
  logic              busy_rd;

  // request decode against the current length
  assign pos_x     = CMP_W'(position);
  assign cnt_x     = CMP_W'(count);
  assign pos_nz    = (position != '0);
  assign rd_ok     = pos_nz && (pos_x <= cnt_x);
  assign ins_ok    = pos_nz && ((pos_x - CMP_W'(1)) <= cnt_x) && (count != CNT_W'(DEPTH));
  assign tgt_in    = ADDR_W'(pos_x - CMP_W'(1));
  assign ins_moves = CNT_W'(cnt_x - (pos_x - CMP_W'(1)));
  assign del_len   = CNT_W'(cnt_x - pos_x + CMP_W'(1));

  assign busy_rd   = (state == S_INS) || (state == S_SCAN) || (state == S_LOC);
  assign ram_re    = busy_rd && (left != '0);
  assign ram_raddr = idx;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = paddr;
    ram_wdata = ram_rdata;
    case (state)
      S_INS: begin
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = paddr + ADDR_W'(1);
        end else if (left == '0) begin
          ram_we    = 1'b1;
          ram_waddr = tgt;
          ram_wdata = val;
        end
      end
      S_SCAN: begin
        if (pend && shift && (paddr != tgt)) begin
          ram_we    = 1'b1;
          ram_waddr = paddr - ADDR_W'(1);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (in_valid) begin
            val    <= item_value;
            tgt    <= tgt_in;
            res_ok <= 1'b0;
            res_rd <= '0;
            res_fp <= '0;
            shift  <= (op == OP_DELETE);
            case (op)
              OP_INSERT: begin
                left  <= ins_moves;
                idx   <= ADDR_W'(count - CNT_W'(1));
                state <= ins_ok ? S_INS : S_RESP;
              end
              OP_DELETE: begin
                left  <= del_len;
                idx   <= tgt_in;
                state <= rd_ok ? S_SCAN : S_RESP;
              end
              OP_GET: begin
                left  <= CNT_W'(1);
                idx   <= tgt_in;
                state <= rd_ok ? S_SCAN : S_RESP;
              end
              OP_LOCATE: begin
                left  <= count;
                idx   <= '0;
                state <= S_LOC;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_INS: begin
          // walk down, each word moves up one slot, then drop in the new value
          pend  <= (left != '0);
          paddr <= idx;
          if (left != '0) begin
            idx  <= idx - ADDR_W'(1);
            left <= left - CNT_W'(1);
          end
          if (!pend && (left == '0)) begin
            count  <= count + CNT_W'(1);
            res_ok <= 1'b1;
            state  <= S_RESP;
          end
        end
        S_SCAN: begin
          // first word read is the target; later words move down one slot
          pend  <= (left != '0);
          paddr <= idx;
          if (left != '0) begin
            idx  <= idx + ADDR_W'(1);
            left <= left - CNT_W'(1);
          end
          if (pend && (paddr == tgt)) begin
            res_rd <= ram_rdata;
          end
          if (!pend && (left == '0)) begin
            res_ok <= 1'b1;
            if (shift) begin
              count <= count - CNT_W'(1);
            end
            state <= S_RESP;
          end
        end
        S_LOC: begin
          pend  <= (left != '0);
          paddr <= idx;
          if (left != '0) begin
            idx  <= idx + ADDR_W'(1);
            left <= left - CNT_W'(1);
          end
          if (pend && (ram_rdata == val)) begin
            res_ok <= 1'b1;
            res_fp <= CNT_W'(paddr) + CNT_W'(1);
            state  <= S_RESP;
          end else if (!pend && (left == '0)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res.ok    = res_ok;
  assign res.rd    = res_rd;
  assign res.fp    = POS_W'(res_fp);
  assign res.len   = POS_W'(count);

endmodule

`default_nettype wire

// ===== rtl/sle_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sle_chk
  import sle_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     ok,
  input wire logic signed [DATA_W-1:0] read_value,
  input wire logic [POS_W-1:0]         found_position,
  input wire logic [POS_W-1:0]         list_length
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(read_value) &&
      $stable(found_position) && $stable(list_length))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a failed request reports no data
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> (read_value == '0) && (found_position == '0))
    else $error("failed request carries data");

  // a match position means success and lies inside the list
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (found_position != '0) |-> ok && (found_position <= list_length))
    else $error("match position out of the list");

endmodule

bind sequential_list_engine sle_chk u_sle_chk (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import sle_pkg::*;
();

  localparam int TOTAL_WORDS = 875;      // directed part plus about 850 random words
  localparam int QUIET_TAIL  = 60;       // last words go without any idling
  localparam int SETTLE      = 300;      // longer than the slowest walk over a full list
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [1:0]              op;
    logic [POS_W-1:0]        pos;
    logic signed [DATA_W-1:0] val;
    bit                      hold;       // wait for every result before sending
  } req_word_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                op = OP_INSERT;
  logic [POS_W-1:0]          position = '0;
  logic signed [DATA_W-1:0]  item_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      ok;
  logic signed [DATA_W-1:0]  read_value;
  logic [POS_W-1:0]          found_position;
  logic [POS_W-1:0]          list_length;

  req_word_t                 pending_q[$];
  res_t                      result_q[$];

  // shadow list the predictor walks, plus the length the generator tracks
  logic signed [DATA_W-1:0]  list_mem [DEPTH];
  int                        list_len;
  int                        gen_len;
  int                        n_queued;

  int                        n_sent = 0;
  int                        n_recv = 0;
  int                        err_cnt = 0;
  int                        cycle_cnt = 0;
  int                        gap_left = 0;
  int                        stall_left = 0;
  int                        calm_left = 0;
  logic                      calm = 1'b0;
  logic                      quiet = 1'b0;

  sequential_list_engine u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .position       (position),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .read_value     (read_value),
    .found_position (found_position),
    .list_length    (list_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one request to the shadow list, returns the result word
  // ---------------------------------------------------------------------------
  function automatic res_t apply_request(logic [1:0] rop, logic [POS_W-1:0] rpos,
                                         logic signed [DATA_W-1:0] rval);
    res_t r;
    int   p;
    r = '0;
    p = int'(rpos);
    case (rop)
      OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
          for (int j = list_len; j > p - 1; j--) list_mem[j] = list_mem[j-1];
          list_mem[p-1] = rval;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          r.rd = list_mem[p-1];
          for (int j = p; j < list_len; j++) list_mem[j-1] = list_mem[j];
          list_len--;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (p >= 1 && p <= list_len) begin
          r.rd = list_mem[p-1];
          r.ok = 1'b1;
        end
      end
      default: begin
        // locate: first match wins
        for (int j = 0; j < list_len; j++) begin
          if (list_mem[j] == rval) begin
            r.fp = POS_W'(j + 1);
            r.ok = 1'b1;
            break;
          end
        end
      end
    endcase
    r.len = POS_W'(list_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers: gen_len follows the list length so positions land in range
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic [1:0] wop, logic [POS_W-1:0] wpos,
                            logic signed [DATA_W-1:0] wval, bit whold = 1'b0);
    req_word_t w;
    int        p;
    w.op   = wop;
    w.pos  = wpos;
    w.val  = wval;
    w.hold = whold;
    pending_q.push_back(w);
    n_queued++;
    p = int'(wpos);
    if (wop == OP_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < DEPTH) gen_len++;
    else if (wop == OP_DELETE && p >= 1 && p <= gen_len) gen_len--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_val();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -1;
      4, 5:    return DATA_W'($urandom_range(0, 7));   // small pool so locate hits
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(logic [1:0] rop);
    int hi;
    hi = (rop == OP_INSERT) ? gen_len + 1 : gen_len;
    if (rop == OP_LOCATE || hi == 0 || $urandom_range(0, 6) == 0)
      return POS_W'($urandom_range(0, 511));
    case ($urandom_range(0, 3))
      0:       return POS_W'(1);
      1:       return POS_W'(hi);
      default: return POS_W'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic queue_random(int ins_w, int del_w);
    int         r;
    logic [1:0] wop;
    r = $urandom_range(0, 99);
    if (r < ins_w)                               wop = OP_INSERT;
    else if (r < ins_w + del_w)                  wop = OP_DELETE;
    else if (r < ins_w + del_w + (100 - ins_w - del_w) / 2) wop = OP_GET;
    else                                         wop = OP_LOCATE;
    queue_word(wop, pick_pos(wop), pick_val());
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence: fill the word queue, release reset, wait for the drain
  // ---------------------------------------------------------------------------
  initial begin
    gen_len  = 0;
    n_queued = 0;

    // empty list: every read and search fails, bad insert positions
    queue_word(OP_GET,    9'd1,   32'sd0);
    queue_word(OP_DELETE, 9'd1,   32'sd0);
    queue_word(OP_LOCATE, 9'd0,   32'sd0);
    queue_word(OP_INSERT, 9'd0,   32'sd9);
    queue_word(OP_INSERT, 9'd2,   32'sd9);
    // build [0, min, max, -1] with head and tail inserts
    queue_word(OP_INSERT, 9'd1,   32'sh8000_0000);
    queue_word(OP_INSERT, 9'd2,   32'sh7FFF_FFFF);
    queue_word(OP_INSERT, 9'd1,   32'sd0);
    queue_word(OP_INSERT, 9'd4,   -32'sd1);
    queue_word(OP_INSERT, 9'd511, 32'sd5);
    queue_word(OP_GET,    9'd0,   32'sd0);
    queue_word(OP_GET,    9'd1,   32'sd0);
    queue_word(OP_GET,    9'd4,   32'sd0);
    queue_word(OP_GET,    9'd5,   32'sd0);
    queue_word(OP_LOCATE, 9'd511, -32'sd1);
    queue_word(OP_LOCATE, 9'd0,   32'sh7FFF_FFFF);
    queue_word(OP_LOCATE, 9'd3,   32'sh1234_5678);
    // duplicate value: locate must report the first one
    queue_word(OP_INSERT, 9'd3,   -32'sd1);
    queue_word(OP_LOCATE, 9'd0,   -32'sd1);
    queue_word(OP_DELETE, 9'd3,   32'sd0);
    queue_word(OP_DELETE, 9'd4,   32'sd0);
    queue_word(OP_DELETE, 9'd511, 32'sd0);
    queue_word(OP_DELETE, 9'd1,   32'sd0, 1'b1);

    // mixed traffic around a short list
    repeat (150) queue_random(40, 25);

    // fill to capacity, then hit the full-list cases
    queue_word(OP_INSERT, pick_pos(OP_INSERT), pick_val(), 1'b1);
    while (gen_len < DEPTH) queue_word(OP_INSERT, pick_pos(OP_INSERT), pick_val());
    queue_word(OP_INSERT, 9'd1, pick_val());
    queue_word(OP_INSERT, POS_W'(DEPTH + 1), pick_val());
    queue_word(OP_INSERT, 9'd511, pick_val());
    queue_word(OP_GET,    POS_W'(DEPTH), 32'sd0);
    queue_word(OP_LOCATE, 9'd0, pick_val());
    queue_word(OP_DELETE, POS_W'(DEPTH), 32'sd0);
    queue_word(OP_INSERT, POS_W'(DEPTH), pick_val());
    queue_word(OP_GET,    POS_W'(DEPTH), 32'sd0);
    queue_word(OP_DELETE, 9'd1, 32'sd0);

    // shrink from a long list, pause once more, then mixed to the end
    repeat (200) queue_random(15, 45);
    queue_word(OP_LOCATE, 9'd0, pick_val(), 1'b1);
    while (n_queued < TOTAL_WORDS) queue_random(35, 30);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || n_sent != n_recv);
    repeat (SETTLE) @(posedge clk);

    if (err_cnt == 0) $display("DONE: 0 errors");
    else              $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents one word at a time, gaps follow an accepted word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      quiet    <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].hold && (in_valid || n_sent != n_recv))) begin
        // nothing left, or holding off until the engine has returned everything
        in_valid <= 1'b0;
      end else begin
        req_word_t w;
        w = pending_q.pop_front();
        in_valid   <= 1'b1;
        op         <= w.op;
        position   <= w.pos;
        item_value <= w.val;
        quiet      <= (pending_q.size() < QUIET_TAIL);
        if (!quiet && !calm && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 7);
      end
    end
  end

  // alternate windows with and without idling
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= !calm;
      calm_left <= $urandom_range(50, 400);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks returned words first, then predicts for the accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      list_len = 0;
      n_sent  <= 0;
      n_recv  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_recv <= n_recv + 1;
        got.ok  = ok;
        got.rd  = read_value;
        got.fp  = found_position;
        got.len = list_length;
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result word with none expected: ok=%0b rd=%0d fp=%0d len=%0d",
                     $realtime, got.ok, $signed(got.rd), got.fp, got.len);
        end else begin
          want = result_q.pop_front();
          if (got.ok !== want.ok || got.rd !== want.rd ||
              got.fp !== want.fp || got.len !== want.len) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: exp ok=%0b rd=%0d fp=%0d len=%0d, got ok=%0b rd=%0d fp=%0d len=%0d",
                       $realtime, want.ok, $signed(want.rd), want.fp, want.len,
                       got.ok, $signed(got.rd), got.fp, got.len);
          end
        end
      end
      if (in_valid && in_ready) begin
        n_sent <= n_sent + 1;
        result_q.push_back(apply_request(op, position, item_value));
      end
    end
  end

  // hard stop well past the slowest legal run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_ctrl.sv
rtl/sequential_list_engine.sv
rtl/sle_chk.sv
dv/testbench.sv
